### src/fbsi_pkg.sv
// fbsi_pkg: shared constants, op and status codes, and the controller/datapath
// command and status structs for the first-byte signature index.
// No dependencies.
package fbsi_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 1024;
  localparam int IDX_W       = 10;   // sorted slot / entry address
  localparam int CNT_W       = 11;   // counts up to MAX_ENTRIES
  localparam int NUM_KEYS    = 256;
  localparam int KEY_W       = 8;
  localparam int GS_DEPTH    = NUM_KEYS + 1;
  localparam int GS_AW       = 9;

  // Op codes
  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_BUILD  = 3'd2;
  localparam logic [2:0] OP_LOOKUP = 3'd3;
  localparam logic [2:0] OP_SLOT   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_BUILT = 2'd2;
  localparam logic [1:0] ST_SLOT_OOR  = 2'd3;

  // Which fields a result beat carries
  typedef enum logic [1:0] {
    RK_STAT,
    RK_LOAD,
    RK_LOOK,
    RK_SLOT
  } res_kind_t;

  // Controller -> datapath
  typedef struct packed {
    logic       cap;         // capture input beat
    logic       do_clear;
    logic       do_load;
    logic       nib_clr;
    logic       idx_zero;
    logic       idx_inc;
    logic       cnt_clr_wr;  // counts[i] = 0
    logic       key_rd;      // read key/owner memories
    logic       key_by_id;   // key read address = sorted id
    logic       cnt_by_idx;  // counts read address = i
    logic       cnt_inc_wr;  // counts[key]++ and nibble update
    logic       pfx_wr;      // group start / running sum write
    logic       gs_last;     // group_start[256]
    logic       pl_wr;       // place entry into sorted order
    logic       set_built;
    logic       res_load;
    res_kind_t  res_kind;
    logic [1:0] res_status;
  } fbsi_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [2:0] op;
    logic       built;
    logic       slot_oor;
    logic       idx_at_count;
    logic       idx_at_last_key;
  } fbsi_stat_t;

endpackage

### src/fbsi_ctrl.sv
// fbsi_ctrl: sequencer for the first-byte signature index. Walks each op and
// the build passes, and owns the result valid flag.
// Depends on fbsi_pkg.
module fbsi_ctrl import fbsi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  fbsi_stat_t stat,
  output fbsi_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_CLR,
    S_CNT_RD,
    S_CNT_K,
    S_CNT_WR,
    S_PFX_RD,
    S_PFX_WR,
    S_PFX_END,
    S_PL_RD,
    S_PL_K,
    S_PL_WR,
    S_LOOK_R,
    S_SLOT_B,
    S_SLOT_R
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_kind   = RK_STAT;
    cmd.res_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.op)
          OP_BUILD: begin
            cmd.nib_clr  = 1'b1;
            cmd.idx_zero = 1'b1;
            state_nxt    = S_CLR;
          end
          OP_LOOKUP: begin
            if (stat.built) begin
              state_nxt = S_LOOK_R;
            end else if (out_free) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_NOT_BUILT;
              state_nxt      = S_IDLE;
            end
          end
          OP_SLOT: begin
            if (stat.built && !stat.slot_oor) begin
              state_nxt = S_SLOT_B;
            end else if (out_free) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = stat.built ? ST_SLOT_OOR : ST_NOT_BUILT;
              state_nxt      = S_IDLE;
            end
          end
          OP_CLEAR: begin
            if (out_free) begin
              cmd.do_clear = 1'b1;
              cmd.res_load = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
          OP_LOAD: begin
            if (out_free) begin
              cmd.do_load  = 1'b1;
              cmd.res_load = 1'b1;
              cmd.res_kind = RK_LOAD;
              state_nxt    = S_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              cmd.res_load = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
        endcase
      end
      // Zero the bucket counters
      S_CLR: begin
        cmd.cnt_clr_wr = 1'b1;
        if (stat.idx_at_last_key) begin
          cmd.idx_zero = 1'b1;
          state_nxt    = S_CNT_RD;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      // Histogram pass
      S_CNT_RD: begin
        if (stat.idx_at_count) begin
          cmd.idx_zero = 1'b1;
          state_nxt    = S_PFX_RD;
        end else begin
          cmd.key_rd = 1'b1;
          state_nxt  = S_CNT_K;
        end
      end
      S_CNT_K: state_nxt = S_CNT_WR;
      S_CNT_WR: begin
        cmd.cnt_inc_wr = 1'b1;
        cmd.idx_inc    = 1'b1;
        state_nxt      = S_CNT_RD;
      end
      // Prefix sum into group starts
      S_PFX_RD: begin
        cmd.cnt_by_idx = 1'b1;
        state_nxt      = S_PFX_WR;
      end
      S_PFX_WR: begin
        cmd.pfx_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = stat.idx_at_last_key ? S_PFX_END : S_PFX_RD;
      end
      S_PFX_END: begin
        cmd.gs_last  = 1'b1;
        cmd.idx_zero = 1'b1;
        state_nxt    = S_PL_RD;
      end
      // Placement pass
      S_PL_RD: begin
        if (stat.idx_at_count) begin
          if (out_free) begin
            cmd.set_built = 1'b1;
            cmd.res_load  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.key_rd = 1'b1;
          state_nxt  = S_PL_K;
        end
      end
      S_PL_K: state_nxt = S_PL_WR;
      S_PL_WR: begin
        cmd.pl_wr   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_PL_RD;
      end
      S_LOOK_R: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RK_LOOK;
          state_nxt    = S_IDLE;
        end
      end
      S_SLOT_B: begin
        cmd.key_rd    = 1'b1;
        cmd.key_by_id = 1'b1;
        state_nxt     = S_SLOT_R;
      end
      S_SLOT_R: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RK_SLOT;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid: set on load, cleared when the beat is taken
  always_comb begin
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/fbsi_datapath.sv
// fbsi_datapath: entry, sorted-id, group-start and counter memories, nibble
// filter tables, pass counters and the result register.
// Depends on fbsi_pkg; driven by fbsi_ctrl.
module fbsi_datapath import fbsi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        in_op,
  input  logic [KEY_W-1:0]  in_key_byte,
  input  logic              in_magic_present,
  input  logic [7:0]        in_owner_id,
  input  logic [IDX_W-1:0]  in_slot_index,
  input  fbsi_cmd_t         cmd,
  output fbsi_stat_t        stat,
  output logic [1:0]        out_status,
  output logic [CNT_W-1:0]  out_group_begin,
  output logic [CNT_W-1:0]  out_group_end,
  output logic              out_any_match,
  output logic              out_filter_pass,
  output logic [7:0]        out_low_mask,
  output logic [7:0]        out_high_mask,
  output logic [KEY_W-1:0]  out_slot_key,
  output logic [7:0]        out_slot_owner,
  output logic [IDX_W-1:0]  out_slot_entry,
  output logic [CNT_W-1:0]  out_entry_count
);

  // Captured beat
  logic [2:0]       op_r;
  logic [KEY_W-1:0] key_r;
  logic             pres_r;
  logic [7:0]       own_r;
  logic [IDX_W-1:0] slot_r;

  // Index state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             built_r, built_nxt;
  logic [7:0]       nib_lo_r [16];
  logic [7:0]       nib_hi_r [16];
  logic [CNT_W-1:0] i_r, at_r;

  // Memories
  logic [KEY_W-1:0] keys_m   [MAX_ENTRIES];
  logic [7:0]       owns_m   [MAX_ENTRIES];
  logic [IDX_W-1:0] sorted_m [MAX_ENTRIES];
  logic [CNT_W-1:0] gs_m     [GS_DEPTH];
  logic [CNT_W-1:0] cnt_m    [NUM_KEYS];

  // Registered read data
  logic [KEY_W-1:0] key_q;
  logic [7:0]       own_q;
  logic [IDX_W-1:0] sid_q;
  logic [CNT_W-1:0] gs_b_q, gs_e_q, cnt_q;

  logic             load_ok, load_full;
  logic [IDX_W-1:0] key_addr;
  logic [7:0]       cnt_raddr, cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;
  logic             cnt_we;
  logic [GS_AW-1:0] gs_b_addr, gs_e_addr;
  logic [7:0]       lo_mask, hi_mask;

  assign load_ok   = pres_r && (count_r != CNT_W'(MAX_ENTRIES));
  assign load_full = pres_r && (count_r == CNT_W'(MAX_ENTRIES));

  assign stat.op              = op_r;
  assign stat.built           = built_r;
  assign stat.slot_oor        = ({1'b0, slot_r} >= count_r);
  assign stat.idx_at_count    = (i_r == count_r);
  assign stat.idx_at_last_key = (i_r[7:0] == 8'hFF);

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r   <= in_op;
      key_r  <= in_key_byte;
      pres_r <= in_magic_present;
      own_r  <= in_owner_id;
      slot_r <= in_slot_index;
    end
  end

  // Count and built flag
  always_comb begin
    count_nxt = count_r;
    built_nxt = built_r;
    if (cmd.do_clear) begin
      count_nxt = '0;
      built_nxt = 1'b0;
    end else if (cmd.do_load && load_ok) begin
      count_nxt = count_r + CNT_W'(1);
      built_nxt = 1'b0;
    end else if (cmd.set_built) begin
      built_nxt = 1'b1;
    end
  end

  // Control registers: count, built, nibble tables, pass index, running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      built_r <= 1'b0;
      i_r     <= '0;
      at_r    <= '0;
      for (int n = 0; n < 16; n++) begin
        nib_lo_r[n] <= '0;
        nib_hi_r[n] <= '0;
      end
    end else begin
      count_r <= count_nxt;
      built_r <= built_nxt;
      if (cmd.idx_zero) begin
        i_r  <= '0;
        at_r <= '0;
      end else begin
        if (cmd.idx_inc) i_r <= i_r + CNT_W'(1);
        if (cmd.pfx_wr) at_r <= at_r + cnt_q;
      end
      if (cmd.do_clear || cmd.nib_clr) begin
        for (int n = 0; n < 16; n++) begin
          nib_lo_r[n] <= '0;
          nib_hi_r[n] <= '0;
        end
      end else if (cmd.cnt_inc_wr) begin
        nib_lo_r[key_q[3:0]] <= nib_lo_r[key_q[3:0]] | (8'd1 << key_q[6:4]);
        nib_hi_r[key_q[7:4]] <= nib_hi_r[key_q[7:4]] | (8'd1 << key_q[6:4]);
      end
    end
  end

  // Entry memories: written on load, read by pass index or by sorted id
  assign key_addr = cmd.key_by_id ? sid_q : i_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.do_load && load_ok) begin
      keys_m[count_r[IDX_W-1:0]] <= key_r;
      owns_m[count_r[IDX_W-1:0]] <= own_r;
    end
    if (cmd.key_rd) begin
      key_q <= keys_m[key_addr];
      own_q <= owns_m[key_addr];
    end
  end

  // Sorted id memory
  always_ff @(posedge clk) begin
    if (cmd.pl_wr) sorted_m[cnt_q[IDX_W-1:0]] <= i_r[IDX_W-1:0];
    sid_q <= sorted_m[slot_r];
  end

  // Group start memory, two read ports for the group bounds
  assign gs_b_addr = {1'b0, key_r};
  assign gs_e_addr = gs_b_addr + GS_AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.pfx_wr || cmd.gs_last) gs_m[i_r[GS_AW-1:0]] <= at_r;
    gs_b_q <= gs_m[gs_b_addr];
    gs_e_q <= gs_m[gs_e_addr];
  end

  // Bucket counters, reused as next-free slot during placement
  assign cnt_raddr = cmd.cnt_by_idx ? i_r[7:0] : key_q;
  assign cnt_we    = cmd.cnt_clr_wr || cmd.cnt_inc_wr || cmd.pfx_wr || cmd.pl_wr;
  assign cnt_waddr = (cmd.cnt_clr_wr || cmd.pfx_wr) ? i_r[7:0] : key_q;

  always_comb begin
    if (cmd.cnt_clr_wr) begin
      cnt_wdata = '0;
    end else if (cmd.pfx_wr) begin
      cnt_wdata = at_r;
    end else begin
      cnt_wdata = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_m[cnt_waddr] <= cnt_wdata;
    cnt_q <= cnt_m[cnt_raddr];
  end

  // Result register
  assign lo_mask = nib_lo_r[key_r[3:0]];
  assign hi_mask = nib_hi_r[key_r[7:4]];

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status      <= ST_OK;
      out_group_begin <= '0;
      out_group_end   <= '0;
      out_any_match   <= 1'b0;
      out_filter_pass <= 1'b0;
      out_low_mask    <= '0;
      out_high_mask   <= '0;
      out_slot_key    <= '0;
      out_slot_owner  <= '0;
      out_slot_entry  <= '0;
      out_entry_count <= count_nxt;
      case (cmd.res_kind)
        RK_STAT: out_status <= cmd.res_status;
        RK_LOAD: out_status <= load_full ? ST_FULL : ST_OK;
        RK_LOOK: begin
          out_group_begin <= gs_b_q;
          out_group_end   <= gs_e_q;
          out_any_match   <= (gs_e_q > gs_b_q);
          out_filter_pass <= |(lo_mask & hi_mask);
          out_low_mask    <= lo_mask;
          out_high_mask   <= hi_mask;
        end
        RK_SLOT: begin
          out_slot_key   <= key_q;
          out_slot_owner <= own_q;
          out_slot_entry <= sid_q;
        end
        default: out_status <= ST_OK;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table size");
  a_pass_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.key_rd && !cmd.key_by_id) |-> (i_r < count_r))
    else $error("build pass read beyond stored entries");
  a_place_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pl_wr |-> (cnt_q < count_r))
    else $error("placement slot beyond stored entries");
  a_slot_built: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_load && cmd.res_kind == RK_SLOT) |-> (built_r && slot_r < count_r))
    else $error("slot result without a valid index");
`endif

endmodule

### src/first_byte_signature_index_unit.sv
// first_byte_signature_index_unit: top level of the first-byte signature index.
// Depends on fbsi_pkg, fbsi_ctrl and fbsi_datapath.
//
// One op beat in, one result beat out. Clear, load, unknown ops and failed
// lookups/slot reads are answered from the execute state; a lookup waits on
// one registered group-start read and a slot read on two dependent registered
// memory reads. Build runs a counter sweep over all 256 key bytes, a histogram
// pass over each entry, a prefix pass over each key byte and a placement pass
// over each entry, all through the single shared bucket counter memory. A new
// beat is accepted once the previous op has finished; a finished result may
// still be waiting on the output.
module first_byte_signature_index_unit import fbsi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_op,
  input  logic [KEY_W-1:0]  in_key_byte,
  input  logic              in_magic_present,
  input  logic [7:0]        in_owner_id,
  input  logic [IDX_W-1:0]  in_slot_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [CNT_W-1:0]  out_group_begin,
  output logic [CNT_W-1:0]  out_group_end,
  output logic              out_any_match,
  output logic              out_filter_pass,
  output logic [7:0]        out_low_mask,
  output logic [7:0]        out_high_mask,
  output logic [KEY_W-1:0]  out_slot_key,
  output logic [7:0]        out_slot_owner,
  output logic [IDX_W-1:0]  out_slot_entry,
  output logic [CNT_W-1:0]  out_entry_count
);

  fbsi_cmd_t  cmd;
  fbsi_stat_t stat;

  // Sequencer
  fbsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and result datapath
  fbsi_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_op            (in_op),
    .in_key_byte      (in_key_byte),
    .in_magic_present (in_magic_present),
    .in_owner_id      (in_owner_id),
    .in_slot_index    (in_slot_index),
    .cmd              (cmd),
    .stat             (stat),
    .out_status       (out_status),
    .out_group_begin  (out_group_begin),
    .out_group_end    (out_group_end),
    .out_any_match    (out_any_match),
    .out_filter_pass  (out_filter_pass),
    .out_low_mask     (out_low_mask),
    .out_high_mask    (out_high_mask),
    .out_slot_key     (out_slot_key),
    .out_slot_owner   (out_slot_owner),
    .out_slot_entry   (out_slot_entry),
    .out_entry_count  (out_entry_count)
  );

endmodule
